### rtl/sfgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfgr_pkg
// Shared types and constants of the stroke font glyph renderer: register
// indexes, input actions, queued commands and configuration bundle.
// ----------------------------------------------------------------------------
package sfgr_pkg;

   // default datapath width of origin and point positions
   localparam int POSITION_BITS_DEF = 32;
   // depth of the command queue between front and back end
   localparam int QUEUE_DEPTH_DEF   = 4;

   // font geometry
   localparam int FONT_CENTER = 82;
   localparam logic [7:0] PEN_UP_BYTE = 8'd32;

   // field widths
   localparam int COORD_W  = 8;
   localparam int IO_POS_W = 32;
   localparam int CSR_W    = 24;
   localparam int DELTA_W  = 10;   // font-unit difference, signed
   localparam int GLYPH_W  = 9;    // glyph offset and width, signed

   typedef enum logic [2:0] {
      CSR_COS_ANGLE   = 3'd0,
      CSR_SIN_ANGLE   = 3'd1,
      CSR_SCALE_X     = 3'd2,
      CSR_SCALE_Y     = 3'd3,
      CSR_CENTERED    = 3'd4,
      CSR_FIXED_WIDTH = 3'd5,
      CSR_MAX_WIDTH   = 3'd6,
      CSR_DESCENDER   = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_SET_ORIGIN  = 2'd0,
      ACT_GLYPH_START = 2'd1,
      ACT_VERTEX      = 2'd2,
      ACT_GLYPH_END   = 2'd3
   } action_type;

   // work handed from front to back end
   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,   // load origin from pos, no result
      OP_POINT   = 2'd1,   // transform vertex, emit point
      OP_ADVANCE = 2'd2    // move origin by glyph width, emit move
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic                       draw;
      logic signed [DELTA_W-1:0]  dx;
      logic signed [DELTA_W-1:0]  dy;
      logic signed [IO_POS_W-1:0] pos_x;
      logic signed [IO_POS_W-1:0] pos_y;
   } cmd_type;

   typedef struct packed {
      logic signed [15:0] cos_angle;
      logic signed [15:0] sin_angle;
      logic [23:0]        scale_x;
      logic [23:0]        scale_y;
      logic               centered;
      logic               fixed_width;
      logic [7:0]         max_width;
      logic signed [7:0]  descender;
   } cfg_type;

endpackage

### rtl/sfgr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfgr_front
// Input side: decodes each transaction, tracks pen and glyph extent state and
// turns vertices, origin loads and glyph ends into queued commands.
// ----------------------------------------------------------------------------
module sfgr_front (
   input  logic                                clock,
   input  logic                                reset,
   input  sfgr_pkg::cfg_type                   cfg,
   input  logic                                accept,
   input  logic [1:0]                          action,
   input  logic [sfgr_pkg::COORD_W-1:0]        coord_a,
   input  logic [sfgr_pkg::COORD_W-1:0]        coord_b,
   input  logic signed [sfgr_pkg::IO_POS_W-1:0] pos_x,
   input  logic signed [sfgr_pkg::IO_POS_W-1:0] pos_y,
   output logic                                push,
   output sfgr_pkg::cmd_type                   cmd
);

   localparam int DW = sfgr_pkg::DELTA_W;
   localparam int GW = sfgr_pkg::GLYPH_W;
   localparam logic signed [DW-1:0] CENTER_D = DW'(sfgr_pkg::FONT_CENTER);
   localparam logic signed [GW-1:0] CENTER_G = GW'(sfgr_pkg::FONT_CENTER);

   logic                   pen_up_ff, pen_up_in;
   logic signed [GW-1:0]   offset_ff, offset_in;
   logic signed [GW-1:0]   width_ff,  width_in;

   logic                   pen_byte;
   logic signed [DW-1:0]   vx_dx, vx_dy, desc_d;
   sfgr_pkg::action_type   act;

   assign act      = sfgr_pkg::action_type'(action);
   assign pen_byte = (coord_a == sfgr_pkg::PEN_UP_BYTE);

   // vertex deltas in font units
   assign desc_d = cfg.centered ? '0 : DW'(cfg.descender);
   assign vx_dx  = $signed({2'b00, coord_a}) - CENTER_D - DW'(offset_ff);
   assign vx_dy  = CENTER_D - $signed({2'b00, coord_b}) - desc_d;

   // decode and glyph state update
   always_comb begin
      pen_up_in = pen_up_ff;
      offset_in = offset_ff;
      width_in  = width_ff;
      push      = 1'b0;
      cmd.op    = sfgr_pkg::OP_LOAD;
      cmd.draw  = 1'b0;
      cmd.dx    = vx_dx;
      cmd.dy    = vx_dy;
      cmd.pos_x = pos_x;
      cmd.pos_y = pos_y;
      case (act)
         sfgr_pkg::ACT_SET_ORIGIN: begin
            push = accept;
         end
         sfgr_pkg::ACT_GLYPH_START: begin
            if (accept) begin
               pen_up_in = 1'b1;
               if (cfg.centered) begin
                  offset_in = '0;
               end else if (cfg.fixed_width) begin
                  offset_in = -$signed({2'b00, cfg.max_width[7:1]});
               end else begin
                  offset_in = $signed({1'b0, coord_a}) - CENTER_G;
               end
               if (cfg.fixed_width) begin
                  width_in = $signed({1'b0, cfg.max_width});
               end else begin
                  width_in = $signed({1'b0, coord_b}) - $signed({1'b0, coord_a});
               end
            end
         end
         sfgr_pkg::ACT_VERTEX: begin
            cmd.op   = sfgr_pkg::OP_POINT;
            cmd.draw = !pen_up_ff;
            if (accept) begin
               if (pen_byte) begin
                  pen_up_in = 1'b1;
               end else begin
                  pen_up_in = 1'b0;
                  push      = 1'b1;
               end
            end
         end
         sfgr_pkg::ACT_GLYPH_END: begin
            cmd.op = sfgr_pkg::OP_ADVANCE;
            cmd.dx = DW'(width_ff);
            cmd.dy = '0;
            push   = accept;
            if (accept) begin
               pen_up_in = 1'b1;
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_up_ff <= 1'b1;
         offset_ff <= '0;
         width_ff  <= '0;
      end else begin
         pen_up_ff <= pen_up_in;
         offset_ff <= offset_in;
         width_ff  <= width_in;
      end
   end

endmodule

### rtl/sfgr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfgr_queue
// Small command FIFO between front and back end, head entry shown directly.
// ----------------------------------------------------------------------------
module sfgr_queue #(
   parameter int DEPTH = sfgr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sfgr_pkg::cmd_type wr_data,
   input  logic              pop,
   output sfgr_pkg::cmd_type rd_data,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   sfgr_pkg::cmd_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/sfgr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfgr_back
// Execution side: scales, rotates and rounds each command's deltas over a
// short multiply sequence, adds the origin with saturation, updates the
// origin and holds the result for the output.
// ----------------------------------------------------------------------------
module sfgr_back #(
   parameter int POSITION_BITS = sfgr_pkg::POSITION_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sfgr_pkg::cfg_type                     cfg,
   input  logic                                  q_empty,
   input  sfgr_pkg::cmd_type                     q_data,
   output logic                                  q_pop,
   input  logic                                  rsp_pop,
   output logic                                  rsp_empty,
   output logic                                  rsp_pen_draw,
   output logic signed [sfgr_pkg::IO_POS_W-1:0]  rsp_out_x,
   output logic signed [sfgr_pkg::IO_POS_W-1:0]  rsp_out_y
);

   localparam int PB      = POSITION_BITS;
   localparam int IOW     = sfgr_pkg::IO_POS_W;
   localparam int SCL_W   = 34;                 // delta times Q8.16 scale
   localparam int MUL_W   = SCL_W + 16;         // times Q2.14
   localparam int SUM_W   = MUL_W + 1;
   localparam int RSH     = 14;
   localparam int ROT_W   = SUM_W - RSH;
   localparam int FW      = ((PB > ROT_W) ? PB : ROT_W) + 1;
   localparam int OW      = (PB > IOW) ? PB : IOW;
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1 << (RSH - 1));
   localparam logic signed [PB-1:0] POS_MAX = {1'b0, {(PB-1){1'b1}}};
   localparam logic signed [PB-1:0] POS_MIN = {1'b1, {(PB-1){1'b0}}};

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCALE  = 5'b00010,
      ST_ROTATE = 5'b00100,
      ST_ROUND  = 5'b01000,
      ST_WRITE  = 5'b10000
   } back_state_type;

   back_state_type          state_ff, state_in;
   sfgr_pkg::cmd_type       cmd_ff;
   logic signed [SCL_W-1:0] xp_ff, yp_ff;
   logic signed [MUL_W-1:0] cxp_ff, syp_ff, sxp_ff, cyp_ff;
   logic signed [ROT_W-1:0] xr_ff, yr_ff;
   logic signed [PB-1:0]    origin_x_ff, origin_x_in;
   logic signed [PB-1:0]    origin_y_ff, origin_y_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_draw_ff;
   logic signed [IOW-1:0]   rsp_x_ff, rsp_y_ff;

   logic signed [SCL_W:0]   xp_full, yp_full;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic signed [FW-1:0]    base_x, base_y, add_x, add_y, tot_x, tot_y;
   logic signed [PB-1:0]    sat_x, sat_y;
   logic signed [OW-1:0]    ext_x, ext_y;
   logic                    is_load, slot_free, do_write;

   // scale stage: font delta times Q8.16 scale
   assign xp_full = cmd_ff.dx * $signed({1'b0, cfg.scale_x});
   assign yp_full = cmd_ff.dy * $signed({1'b0, cfg.scale_y});

   // rounding stage: exact sums, then divide by 2^14 rounding half up
   assign sum_x = SUM_W'(cxp_ff) - SUM_W'(syp_ff) + HALF;
   assign sum_y = SUM_W'(sxp_ff) + SUM_W'(cyp_ff) + HALF;

   // write stage: origin plus rotated point, or plain load of pos
   assign is_load = (cmd_ff.op == sfgr_pkg::OP_LOAD);
   assign base_x  = is_load ? FW'(cmd_ff.pos_x) : FW'(origin_x_ff);
   assign base_y  = is_load ? FW'(cmd_ff.pos_y) : FW'(origin_y_ff);
   assign add_x   = is_load ? '0 : FW'(xr_ff);
   assign add_y   = is_load ? '0 : FW'(yr_ff);
   assign tot_x   = base_x + add_x;
   assign tot_y   = base_y + add_y;

   always_comb begin
      if (tot_x > FW'(POS_MAX)) begin
         sat_x = POS_MAX;
      end else if (tot_x < FW'(POS_MIN)) begin
         sat_x = POS_MIN;
      end else begin
         sat_x = tot_x[PB-1:0];
      end
      if (tot_y > FW'(POS_MAX)) begin
         sat_y = POS_MAX;
      end else if (tot_y < FW'(POS_MIN)) begin
         sat_y = POS_MIN;
      end else begin
         sat_y = tot_y[PB-1:0];
      end
   end

   assign ext_x = OW'(sat_x);
   assign ext_y = OW'(sat_y);

   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign do_write  = (state_ff == ST_WRITE) && (is_load || slot_free);
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE:  state_in = ST_ROTATE;
         ST_ROTATE: state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (do_write) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // origin and output slot
   always_comb begin
      origin_x_in  = origin_x_ff;
      origin_y_in  = origin_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      if (do_write) begin
         if (cmd_ff.op != sfgr_pkg::OP_POINT) begin
            origin_x_in = sat_x;
            origin_y_in = sat_y;
         end
         if (!is_load) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_data;
      end
      if (state_ff == ST_SCALE) begin
         xp_ff <= xp_full[SCL_W-1:0];
         yp_ff <= yp_full[SCL_W-1:0];
      end
      if (state_ff == ST_ROTATE) begin
         cxp_ff <= cfg.cos_angle * xp_ff;
         syp_ff <= cfg.sin_angle * yp_ff;
         sxp_ff <= cfg.sin_angle * xp_ff;
         cyp_ff <= cfg.cos_angle * yp_ff;
      end
      if (state_ff == ST_ROUND) begin
         xr_ff <= sum_x[SUM_W-1:RSH];
         yr_ff <= sum_y[SUM_W-1:RSH];
      end
      if (do_write && !is_load) begin
         rsp_draw_ff <= cmd_ff.draw;
         rsp_x_ff    <= ext_x[IOW-1:0];
         rsp_y_ff    <= ext_y[IOW-1:0];
      end
   end

   assign rsp_empty    = !rsp_valid_ff;
   assign rsp_pen_draw = rsp_draw_ff;
   assign rsp_out_x    = rsp_x_ff;
   assign rsp_out_y    = rsp_y_ff;

endmodule

### rtl/stroke_font_glyph_renderer.sv
`timescale 1ns / 1ps
// A point is registered in the command queue, then in the back end's scale,
// rotate, round and write states. The back end takes the next command only
// after writing the last, which waits while the output slot is full.
// Glyph start and pen up items never reach the back end.
// Reset (synchronous, active high) restores register defaults, clears the
// origin, raises the pen and empties the command queue and output slot.
// ----------------------------------------------------------------------------
// stroke_font_glyph_renderer
// Stroke font glyph renderer top level: register file, front end decoder,
// command queue and transform back end.
// ----------------------------------------------------------------------------
module stroke_font_glyph_renderer #(
   parameter int POSITION_BITS = sfgr_pkg::POSITION_BITS_DEF,
   parameter int QUEUE_DEPTH   = sfgr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // item input
   input  logic                                  push,
   output logic                                  full,
   input  logic [1:0]                            req_action,
   input  logic [sfgr_pkg::COORD_W-1:0]          req_coord_a,
   input  logic [sfgr_pkg::COORD_W-1:0]          req_coord_b,
   input  logic signed [sfgr_pkg::IO_POS_W-1:0]  req_pos_x,
   input  logic signed [sfgr_pkg::IO_POS_W-1:0]  req_pos_y,
   // point output
   output logic                                  empty,
   input  logic                                  pop,
   output logic                                  rsp_pen_draw,
   output logic signed [sfgr_pkg::IO_POS_W-1:0]  rsp_out_x,
   output logic signed [sfgr_pkg::IO_POS_W-1:0]  rsp_out_y,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [2:0]                            csr_index,
   input  logic [sfgr_pkg::CSR_W-1:0]            csr_data
);

   sfgr_pkg::cfg_type  cfg_ff, cfg_in;
   sfgr_pkg::cmd_type  front_cmd, q_data;
   logic               front_push, q_full, q_empty, q_pop, accept;

   assign csr_ready = 1'b1;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (sfgr_pkg::csr_index_type'(csr_index))
            sfgr_pkg::CSR_COS_ANGLE:   cfg_in.cos_angle   = $signed(csr_data[15:0]);
            sfgr_pkg::CSR_SIN_ANGLE:   cfg_in.sin_angle   = $signed(csr_data[15:0]);
            sfgr_pkg::CSR_SCALE_X:     cfg_in.scale_x     = csr_data;
            sfgr_pkg::CSR_SCALE_Y:     cfg_in.scale_y     = csr_data;
            sfgr_pkg::CSR_CENTERED:    cfg_in.centered    = csr_data[0];
            sfgr_pkg::CSR_FIXED_WIDTH: cfg_in.fixed_width = csr_data[0];
            sfgr_pkg::CSR_MAX_WIDTH:   cfg_in.max_width   = csr_data[7:0];
            sfgr_pkg::CSR_DESCENDER:   cfg_in.descender   = $signed(csr_data[7:0]);
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_angle   <= 16'sd16384;
         cfg_ff.sin_angle   <= '0;
         cfg_ff.scale_x     <= 24'd65536;
         cfg_ff.scale_y     <= 24'd65536;
         cfg_ff.centered    <= 1'b0;
         cfg_ff.fixed_width <= 1'b0;
         cfg_ff.max_width   <= '0;
         cfg_ff.descender   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input side accepts whenever the command queue has room
   assign full   = q_full;
   assign accept = push && !q_full;

   sfgr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .accept  (accept),
      .action  (req_action),
      .coord_a (req_coord_a),
      .coord_b (req_coord_b),
      .pos_x   (req_pos_x),
      .pos_y   (req_pos_y),
      .push    (front_push),
      .cmd     (front_cmd)
   );

   sfgr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .wr_data (front_cmd),
      .pop     (q_pop),
      .rd_data (q_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   sfgr_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_empty      (q_empty),
      .q_data       (q_data),
      .q_pop        (q_pop),
      .rsp_pop      (pop),
      .rsp_empty    (empty),
      .rsp_pen_draw (rsp_pen_draw),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y)
   );

endmodule
